>>> src/sump_pump_level_controller_top_assert.svh
// ---------------------------------------------------------------------------
// sump pump level controller assertion macros
// concurrent checks, disabled during reset
// ---------------------------------------------------------------------------
`ifndef SUMP_PUMP_LEVEL_CONTROLLER_TOP_ASSERT_SVH
`define SUMP_PUMP_LEVEL_CONTROLLER_TOP_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define SPLC_ASSERT_NOW(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("splc same-cycle check failed");

// condition must hold in the cycle after the trigger
`define SPLC_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("splc next-cycle check failed");

`endif

>>> src/splc_pkg.sv
// ---------------------------------------------------------------------------
// splc_pkg
// shared widths, codes and reset values of the sump pump level controller
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package splc_pkg;

  // default parameter values
  localparam int TIMER_WIDTH_DEF    = 20;
  localparam int DEBOUNCE_WIDTH_DEF = 16;
  localparam int HOURS_IN_DAY_DEF   = 24;

  // fixed field and register widths
  localparam int CFG_DATA_WIDTH  = 20;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int LIMIT_WIDTH     = 16;
  localparam int TICKS_WIDTH     = 20;
  localparam int HOURS_WIDTH     = 5;
  localparam int MODE_WIDTH      = 2;
  localparam int STATUS_WIDTH    = 3;
  localparam int PHASE_WIDTH     = 2;
  localparam int IN_DATA_WIDTH   = 8;
  localparam int OUT_DATA_WIDTH  = 8;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SENSOR_INVERT       = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SWITCH_STABLE_TICKS = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEVEL_RISE_TICKS    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEVEL_FALL_TICKS    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PUMP_DELAY_TICKS    = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DRAIN_RUN_TICKS     = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FIRST_DRAIN_TICKS   = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOUR_TICKS          = 3'd7;

  // register reset values
  localparam logic [LIMIT_WIDTH-1:0] SWITCH_STABLE_RESET = 16'd50;
  localparam logic [LIMIT_WIDTH-1:0] LEVEL_RISE_RESET    = 16'd500;
  localparam logic [LIMIT_WIDTH-1:0] LEVEL_FALL_RESET    = 16'd100;
  localparam logic [TICKS_WIDTH-1:0] PUMP_DELAY_RESET    = 20'd30000;
  localparam logic [TICKS_WIDTH-1:0] DRAIN_RUN_RESET     = 20'd1000;
  localparam logic [TICKS_WIDTH-1:0] FIRST_DRAIN_RESET   = 20'd6000;
  localparam logic [TICKS_WIDTH-1:0] HOUR_TICKS_RESET    = 20'd360000;

  // tick modes
  localparam logic [MODE_WIDTH-1:0] MODE_PLAIN     = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_FORCE_ON  = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_FORCE_OFF = 2'd2;

  // status codes
  localparam logic [STATUS_WIDTH-1:0] ST_STOPPED     = 3'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_DELAYED     = 3'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_PUMP_TIMED  = 3'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_PUMP_TOP    = 3'd3;
  localparam logic [STATUS_WIDTH-1:0] ST_SENSOR_FAIL = 3'd4;

  // drain phases
  localparam logic [PHASE_WIDTH-1:0] PHASE_NONE   = 2'd0;
  localparam logic [PHASE_WIDTH-1:0] PHASE_HOURLY = 2'd1;
  localparam logic [PHASE_WIDTH-1:0] PHASE_DAILY  = 2'd2;

  // pump actions chosen after the level update
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_STOP,
    ACT_DELAY,
    ACT_START
  } action_t;

endpackage

`default_nettype wire

>>> src/sump_pump_level_controller_top.sv
// ---------------------------------------------------------------------------
// sump_pump_level_controller_top
// debounced float switch voting, pump control and periodic drain runs
// ---------------------------------------------------------------------------
// usage:
//   s_* channel: one 10 ms tick per transaction; s_tdata carries the raw
//   bottom and top float switches, s_tuser the tick mode (plain, force pump
//   on, force pump off).
//   m_* channel: one result per tick with pump drive, status, bad-sensor
//   flag, both debounced levels and the draining flag.
//   cfg_*: register writes; the user must make them only while no tick
//   is in flight, and the block itself does not enforce this.
// throughput: one tick per clock while s_tready is high; the whole update
//   of debouncers, votes, timers and pump state is one combinational pass
//   between the state and the result register.
// stalls:
//   a two-entry output stage (result register plus skid register) keeps
//   s_tready high while one result waits; s_tready drops only when both
//   hold a result.
// reset:
//   rst (synchronous, active high) restores register defaults, clears all
//   debouncers and the pump, and arms the first drain run.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sump_pump_level_controller_top_assert.svh"

module sump_pump_level_controller_top #(
  parameter int TIMER_WIDTH    = splc_pkg::TIMER_WIDTH_DEF,
  parameter int DEBOUNCE_WIDTH = splc_pkg::DEBOUNCE_WIDTH_DEF,
  parameter int HOURS_IN_DAY   = splc_pkg::HOURS_IN_DAY_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // input ticks
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // s_tdata: bottom_switches[2:0], top_switches[5:3], zero pad [7:6]
  input  wire logic [splc_pkg::IN_DATA_WIDTH-1:0]    s_tdata,
  // s_tuser: mode[1:0]
  input  wire logic [splc_pkg::MODE_WIDTH-1:0]       s_tuser,
  // results
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // m_tdata: pump_drive[0], status[3:1], bad_sensor_flag[4], bottom_high[5],
  //          top_high[6], draining[7]
  output logic [splc_pkg::OUT_DATA_WIDTH-1:0]        m_tdata,
  // configuration writes
  input  wire logic                                  cfg_we,
  input  wire logic [splc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [splc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  import splc_pkg::*;

  localparam int TW = TIMER_WIDTH;
  localparam int DW = DEBOUNCE_WIDTH;
  localparam int CW = (DW > LIMIT_WIDTH) ? DW : LIMIT_WIDTH;
  localparam logic [DW-1:0] DMASK = {DW{1'b1}};
  localparam logic [HOURS_WIDTH-1:0] DAY_EXTRA_HOURS = HOURS_WIDTH'(HOURS_IN_DAY - 1);

  // configuration registers
  logic                   sensor_invert;
  logic [LIMIT_WIDTH-1:0] switch_stable_ticks;
  logic [LIMIT_WIDTH-1:0] level_rise_ticks;
  logic [LIMIT_WIDTH-1:0] level_fall_ticks;
  logic [TICKS_WIDTH-1:0] pump_delay_ticks;
  logic [TICKS_WIDTH-1:0] drain_run_ticks;
  logic [TICKS_WIDTH-1:0] first_drain_ticks;
  logic [TICKS_WIDTH-1:0] hour_ticks;

  // controller state
  logic [5:0]             switch_stable;
  logic [DW-1:0]          switch_count [6];
  logic [1:0]             level_stable;
  logic [DW-1:0]          level_count [2];
  logic [1:0]             level_seen;
  logic                   pump_running;
  logic                   pump_timer_active;
  logic [TW-1:0]          pump_timer;
  logic                   drain_wait_active;
  logic [TW-1:0]          drain_wait;
  logic [HOURS_WIDTH-1:0] drain_hours_left;
  logic [PHASE_WIDTH-1:0] drain_phase;
  logic [STATUS_WIDTH-1:0] status_reg;
  logic                   bad_sensor_reg;
  logic                   first_pass;

  logic [5:0]             switch_stable_next;
  logic [DW-1:0]          switch_count_next [6];
  logic [1:0]             level_stable_next;
  logic [DW-1:0]          level_count_next [2];
  logic                   pump_running_next;
  logic                   pump_timer_active_next;
  logic [TW-1:0]          pump_timer_next;
  logic                   drain_wait_active_next;
  logic [TW-1:0]          drain_wait_next;
  logic [HOURS_WIDTH-1:0] drain_hours_left_next;
  logic [PHASE_WIDTH-1:0] drain_phase_next;
  logic [STATUS_WIDTH-1:0] status_next;
  logic                   bad_sensor_next;

  // output stage
  logic                      skid_valid;
  logic [OUT_DATA_WIDTH-1:0] skid_data;
  logic [OUT_DATA_WIDTH-1:0] result;
  logic                      accept;

  // working signals of the single pass
  logic [5:0]             raw;
  logic [1:0]             vote;
  logic [1:0]             changed;
  logic [DW:0]            deb;
  logic                   drain_fire;
  logic                   pump_fire;
  action_t                action;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !skid_valid;

  // returns {stable, count}
  function automatic logic [DW:0] debounce(input logic now, input logic stable,
                                           input logic [DW-1:0] count,
                                           input logic [LIMIT_WIDTH-1:0] limit);
    logic [DW-1:0]          c1;
    logic [LIMIT_WIDTH-1:0] lim;
    logic [DW:0]            r;
    lim = (limit == '0) ? LIMIT_WIDTH'(1) : limit;
    c1  = (count != DMASK) ? count + DW'(1) : count;
    if (now == stable) begin
      r = {stable, {DW{1'b0}}};
    end else if (CW'(c1) >= CW'(lim)) begin
      r = {now, {DW{1'b0}}};
    end else begin
      r = {stable, c1};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_invert       <= 1'b0;
      switch_stable_ticks <= SWITCH_STABLE_RESET;
      level_rise_ticks    <= LEVEL_RISE_RESET;
      level_fall_ticks    <= LEVEL_FALL_RESET;
      pump_delay_ticks    <= PUMP_DELAY_RESET;
      drain_run_ticks     <= DRAIN_RUN_RESET;
      first_drain_ticks   <= FIRST_DRAIN_RESET;
      hour_ticks          <= HOUR_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SENSOR_INVERT:       sensor_invert       <= cfg_data[0];
        CFG_SWITCH_STABLE_TICKS: switch_stable_ticks <= cfg_data[LIMIT_WIDTH-1:0];
        CFG_LEVEL_RISE_TICKS:    level_rise_ticks    <= cfg_data[LIMIT_WIDTH-1:0];
        CFG_LEVEL_FALL_TICKS:    level_fall_ticks    <= cfg_data[LIMIT_WIDTH-1:0];
        CFG_PUMP_DELAY_TICKS:    pump_delay_ticks    <= cfg_data[TICKS_WIDTH-1:0];
        CFG_DRAIN_RUN_TICKS:     drain_run_ticks     <= cfg_data[TICKS_WIDTH-1:0];
        CFG_FIRST_DRAIN_TICKS:   first_drain_ticks   <= cfg_data[TICKS_WIDTH-1:0];
        CFG_HOUR_TICKS:          hour_ticks          <= cfg_data[TICKS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pump_running_next       = pump_running;
    pump_timer_active_next  = pump_timer_active;
    pump_timer_next         = pump_timer;
    drain_wait_active_next  = drain_wait_active;
    drain_wait_next         = drain_wait;
    drain_hours_left_next   = drain_hours_left;
    drain_phase_next        = drain_phase;
    status_next             = status_reg;
    drain_fire              = 1'b0;
    pump_fire               = 1'b0;
    action                  = ACT_NONE;
    deb                     = '0;

    // forced pump commands act before the tick
    if (s_tuser == MODE_FORCE_ON) begin
      pump_running_next = 1'b1;
    end else if (s_tuser == MODE_FORCE_OFF) begin
      pump_running_next = 1'b0;
    end

    // drain timer
    if (drain_wait_active) begin
      if (drain_wait <= TW'(1)) begin
        drain_wait_active_next = 1'b0;
        drain_wait_next        = '0;
        drain_fire             = 1'b1;
      end else begin
        drain_wait_next = drain_wait - TW'(1);
      end
    end
    if (drain_fire) begin
      if (drain_hours_left != '0) begin
        // another hour segment of a long wait
        drain_hours_left_next  = drain_hours_left - HOURS_WIDTH'(1);
        drain_wait_next        = TW'(hour_ticks);
        drain_wait_active_next = 1'b1;
      end else if (!pump_running_next) begin
        pump_running_next      = 1'b1;
        drain_wait_next        = TW'(drain_run_ticks);
        drain_hours_left_next  = '0;
        drain_wait_active_next = 1'b1;
      end else begin
        pump_running_next = 1'b0;
        status_next       = ST_STOPPED;
        if (drain_phase == PHASE_DAILY) begin
          drain_phase_next = PHASE_NONE;
        end else if (drain_phase == PHASE_HOURLY) begin
          drain_phase_next       = PHASE_DAILY;
          drain_wait_next        = TW'(hour_ticks);
          drain_hours_left_next  = DAY_EXTRA_HOURS;
          drain_wait_active_next = 1'b1;
        end
      end
    end

    // switch debounce and two-of-three vote
    raw = {s_tdata[5:3], s_tdata[2:0]} ^ {6{sensor_invert}};
    for (int i = 0; i < 6; i++) begin
      deb = debounce(raw[i], switch_stable[i], switch_count[i], switch_stable_ticks);
      switch_stable_next[i] = deb[DW];
      switch_count_next[i]  = deb[DW-1:0];
    end
    for (int g = 0; g < 2; g++) begin
      vote[g] = (switch_stable_next[3*g]   && switch_stable_next[3*g+1]) ||
                (switch_stable_next[3*g]   && switch_stable_next[3*g+2]) ||
                (switch_stable_next[3*g+1] && switch_stable_next[3*g+2]);
      deb = debounce(vote[g], level_stable[g], level_count[g],
                     vote[g] ? level_rise_ticks : level_fall_ticks);
      level_stable_next[g] = deb[DW];
      level_count_next[g]  = deb[DW-1:0];
      changed[g]           = level_stable_next[g] != level_seen[g];
    end

    bad_sensor_next = (|switch_stable_next[5:3]) && !(&switch_stable_next[2:0]);

    // pick the pump action
    if (!(first_pass || changed[0] || changed[1])) begin
      if (pump_timer_active) begin
        if (pump_timer <= TW'(1)) begin
          pump_timer_active_next = 1'b0;
          pump_timer_next        = '0;
          pump_fire              = 1'b1;
        end else begin
          pump_timer_next = pump_timer - TW'(1);
        end
      end
      if (pump_fire) begin
        if (pump_running_next) begin
          action = level_stable_next[0] ? ACT_DELAY : ACT_STOP;
        end else begin
          action = ACT_START;
        end
      end
    end else if (level_stable_next[0] && level_stable_next[1]) begin
      action = ACT_START;
    end else if (level_stable_next[0]) begin
      action = changed[0] ? ACT_DELAY : ACT_START;
    end else begin
      action = ACT_STOP;
    end

    case (action)
      ACT_STOP: begin
        pump_running_next      = 1'b0;
        pump_timer_active_next = 1'b0;
        if (!level_stable_next[0] && level_stable_next[1]) begin
          status_next = ST_SENSOR_FAIL;
        end else begin
          status_next = ST_STOPPED;
          // pump stopped normally: drain again in one hour
          if (!drain_wait_active_next) begin
            drain_phase_next       = PHASE_HOURLY;
            drain_wait_next        = TW'(hour_ticks);
            drain_hours_left_next  = '0;
            drain_wait_active_next = 1'b1;
          end
        end
      end
      ACT_DELAY: begin
        pump_running_next      = 1'b0;
        drain_wait_active_next = 1'b0;
        pump_timer_next        = TW'(pump_delay_ticks);
        pump_timer_active_next = 1'b1;
        status_next            = ST_DELAYED;
      end
      ACT_START: begin
        // cancel a pending drain run, stopping the pump it holds on
        if (drain_wait_active_next) begin
          drain_wait_active_next = 1'b0;
          pump_running_next      = 1'b0;
        end
        if (level_stable_next[0]) begin
          pump_running_next      = 1'b1;
          pump_timer_active_next = 1'b0;
          if (level_stable_next[1]) begin
            status_next = ST_PUMP_TOP;
          end else begin
            pump_timer_next        = TW'(pump_delay_ticks);
            pump_timer_active_next = 1'b1;
            status_next            = ST_PUMP_TIMED;
          end
        end
      end
      default: ;
    endcase

    result = {pump_running_next && drain_wait_active_next, level_stable_next[1],
              level_stable_next[0], bad_sensor_next, status_next, pump_running_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_stable      <= '0;
      level_stable       <= '0;
      level_seen         <= '0;
      pump_running       <= 1'b0;
      pump_timer_active  <= 1'b0;
      pump_timer         <= '0;
      drain_wait_active  <= 1'b1;
      drain_wait         <= TW'(FIRST_DRAIN_RESET);
      drain_hours_left   <= '0;
      drain_phase        <= PHASE_NONE;
      status_reg         <= ST_STOPPED;
      bad_sensor_reg     <= 1'b0;
      first_pass         <= 1'b1;
      for (int i = 0; i < 6; i++) begin
        switch_count[i] <= '0;
      end
      for (int g = 0; g < 2; g++) begin
        level_count[g] <= '0;
      end
    end else if (accept) begin
      switch_stable      <= switch_stable_next;
      level_stable       <= level_stable_next;
      level_seen         <= level_stable_next;
      pump_running       <= pump_running_next;
      pump_timer_active  <= pump_timer_active_next;
      pump_timer         <= pump_timer_next;
      drain_wait_active  <= drain_wait_active_next;
      drain_wait         <= drain_wait_next;
      drain_hours_left   <= drain_hours_left_next;
      drain_phase        <= drain_phase_next;
      status_reg         <= status_next;
      bad_sensor_reg     <= bad_sensor_next;
      first_pass         <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        switch_count[i] <= switch_count_next[i];
      end
      for (int g = 0; g < 2; g++) begin
        level_count[g] <= level_count_next[g];
      end
    end
  end

  // result register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid   <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!m_tvalid || m_tready) begin
        m_tdata <= result;
      end else begin
        skid_data <= result;
      end
    end else if (m_tready && skid_valid) begin
      m_tdata <= skid_data;
    end
  end

  `SPLC_ASSERT_NOW(a_skid_behind_result, clk, rst, skid_valid, m_tvalid)
  `SPLC_ASSERT_NEXT(a_stall_fills_skid, clk, rst, accept && m_tvalid && !m_tready, skid_valid)
  `SPLC_ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, m_tvalid)
  `SPLC_ASSERT_NEXT(a_first_pass_done, clk, rst, accept, !first_pass)

endmodule

`default_nettype wire
